/* src/ramx_pkg.sv */
`timescale 1ns / 1ps
package ramx_pkg;

	localparam int STAMP_W = 15;
	localparam int ID_W = 4;
	localparam int NCNT_W = 5;
	localparam int CNT_W = 4;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 5;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 2'd1;

	// input mode codes
	localparam logic [1:0] MODE_REQUEST = 2'd0;
	localparam logic [1:0] MODE_RELEASE = 2'd1;
	localparam logic [1:0] MODE_MESSAGE = 2'd2;

	// received message kinds
	localparam logic [1:0] MSG_STARTED  = 2'd0;
	localparam logic [1:0] MSG_DONE     = 2'd1;
	localparam logic [1:0] MSG_CS_REQ   = 2'd2;
	localparam logic [1:0] MSG_CS_REPLY = 2'd3;

	typedef enum logic [1:0] {
		ACT_MULTICAST = 2'd0,
		ACT_REPLY     = 2'd1,
		ACT_GRANT     = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		PH_FREE = 2'd0,
		PH_WAIT = 2'd1,
		PH_BUSY = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		ST_IDLE         = 2'd0,
		ST_RESULT       = 2'd1,
		ST_RESULT_GRANT = 2'd2,
		ST_SCAN         = 2'd3
	} ctrl_state_t;

	typedef struct packed {
		logic accept;
		logic load_grant;
		logic scan_step;
	} cmd_t;

	typedef struct packed {
		logic res_now;
		logic grant_next;
		logic scan_go;
		logic bit_hit;
		logic work_empty;
		logic out_last;
	} sts_t;

endpackage

/* src/ramx_if.sv */
`timescale 1ns / 1ps
interface ramx_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [1:0]  msg_kind;
	logic [3:0]  source_node;
	logic [14:0] stamp;

	modport source (output valid, mode, msg_kind, source_node, stamp, input ready);
	modport sink (input valid, mode, msg_kind, source_node, stamp, output ready);
endinterface

interface ramx_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [3:0] dest_node;
	logic [1:0] node_phase;
	logic [3:0] started_seen;
	logic [3:0] done_seen;
	logic       last_of_run;

	modport source (output valid, action, dest_node, node_phase, started_seen, done_seen,
		last_of_run, input ready);
	modport sink (input valid, action, dest_node, node_phase, started_seen, done_seen,
		last_of_run, output ready);
endinterface

interface ramx_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [4:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* src/ricart_agrawala_mutex_node.sv */
`timescale 1ns / 1ps
// Channel  Role    Payload
// item     sink    mode, msg_kind, source_node, stamp
// result   source  action, dest_node, node_phase, started_seen, done_seen, last_of_run
// cfg      sink    index, data (always ready)
//
// One request is taken at a time; it is decoded in its accept cycle, and each result
// is held in the output register until it is taken; an item with no result gives none.
// A release sends one reply per deferred node in range, scanning the nodes in order
// from 1 up to the last deferred one (at most MAX_NODES - 1).
// Reset clears the node state and loads own_node_id = 1, node_count = 2.
// A stalled result holds its payload; no request is accepted until the last one goes.
module ricart_agrawala_mutex_node #(
	parameter int MAX_NODES = 16
) (
	input logic            clk,
	input logic            arst_n,
	ramx_in_if.sink        item,
	ramx_out_if.source     result,
	ramx_cfg_if.sink       cfg
);

	ramx_pkg::cmd_t cmd;
	ramx_pkg::sts_t sts;

	assign cfg.ready = 1'b1;

	ramx_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item.valid),
		.item_ready   (item.ready),
		.result_valid (result.valid),
		.result_ready (result.ready),
		.sts          (sts),
		.cmd          (cmd)
	);

	ramx_dp #(
		.MAX_NODES (MAX_NODES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_write    (cfg.valid),
		.cfg_index    (cfg.index),
		.cfg_data     (cfg.data),
		.mode         (item.mode),
		.msg_kind     (item.msg_kind),
		.source_node  (item.source_node),
		.stamp        (item.stamp),
		.action       (result.action),
		.dest_node    (result.dest_node),
		.node_phase   (result.node_phase),
		.started_seen (result.started_seen),
		.done_seen    (result.done_seen),
		.last_of_run  (result.last_of_run)
	);

`ifndef NO_ASSERTIONS
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		item.ready |-> !result.valid)
		else $error("request accepted while a result is pending");
	a_grant_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.action == ramx_pkg::ACT_GRANT
		|-> result.node_phase == ramx_pkg::PH_BUSY)
		else $error("entry granted but node not busy");
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.ready && !result.last_of_run |=> !item.ready)
		else $error("new request taken before the run finished");
	a_scan_free: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.action == ramx_pkg::ACT_REPLY && !result.last_of_run
		|-> result.node_phase == ramx_pkg::PH_FREE)
		else $error("deferred reply sent while node not free");
`endif

endmodule

/* src/ramx_ctrl.sv */
`timescale 1ns / 1ps
module ramx_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_ready,
	output logic           result_valid,
	input  logic           result_ready,
	input  ramx_pkg::sts_t sts,
	output ramx_pkg::cmd_t cmd
);

	ramx_pkg::ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ramx_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ramx_pkg::ST_IDLE: begin
				if (item_valid) begin
					if (sts.scan_go) begin
						state_d = ramx_pkg::ST_SCAN;
					end else if (sts.grant_next) begin
						state_d = ramx_pkg::ST_RESULT_GRANT;
					end else if (sts.res_now) begin
						state_d = ramx_pkg::ST_RESULT;
					end
				end
			end
			ramx_pkg::ST_RESULT_GRANT: begin
				if (result_ready) begin
					state_d = ramx_pkg::ST_RESULT;
				end
			end
			ramx_pkg::ST_RESULT: begin
				if (result_ready) begin
					state_d = sts.out_last ? ramx_pkg::ST_IDLE : ramx_pkg::ST_SCAN;
				end
			end
			ramx_pkg::ST_SCAN: begin
				if (sts.bit_hit) begin
					state_d = ramx_pkg::ST_RESULT;
				end
			end
			default: begin
				state_d = ramx_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		item_ready     = 1'b0;
		result_valid   = 1'b0;
		cmd.accept     = 1'b0;
		cmd.load_grant = 1'b0;
		cmd.scan_step  = 1'b0;
		unique case (state_q)
			ramx_pkg::ST_IDLE: begin
				item_ready = 1'b1;
				cmd.accept = item_valid;
			end
			ramx_pkg::ST_RESULT_GRANT: begin
				result_valid   = 1'b1;
				cmd.load_grant = result_ready;
			end
			ramx_pkg::ST_RESULT: begin
				result_valid = 1'b1;
			end
			ramx_pkg::ST_SCAN: begin
				cmd.scan_step = 1'b1;
			end
			default: begin
				item_ready = 1'b0;
			end
		endcase
	end

`ifndef NO_ASSERTIONS
	a_scan_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ramx_pkg::ST_SCAN |-> !sts.work_empty)
		else $error("scan running with no deferred request left");
	a_single_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.accept, cmd.load_grant, cmd.scan_step}))
		else $error("more than one datapath command in a cycle");
	a_grant_follows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_grant |=> state_q == ramx_pkg::ST_RESULT && sts.out_last)
		else $error("grant after multicast not presented as final result");
`endif

endmodule

/* src/ramx_dp.sv */
`timescale 1ns / 1ps
module ramx_dp #(
	parameter int MAX_NODES = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  ramx_pkg::cmd_t                       cmd,
	output ramx_pkg::sts_t                       sts,
	input  logic                                 cfg_write,
	input  logic [ramx_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ramx_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic [1:0]                           mode,
	input  logic [1:0]                           msg_kind,
	input  logic [ramx_pkg::ID_W-1:0]            source_node,
	input  logic [ramx_pkg::STAMP_W-1:0]         stamp,
	output logic [1:0]                           action,
	output logic [ramx_pkg::ID_W-1:0]            dest_node,
	output logic [1:0]                           node_phase,
	output logic [ramx_pkg::CNT_W-1:0]           started_seen,
	output logic [ramx_pkg::CNT_W-1:0]           done_seen,
	output logic                                 last_of_run
);

	localparam int EW = $clog2(MAX_NODES + 1);
	localparam int IW = $clog2(MAX_NODES);
	localparam logic [ramx_pkg::CNT_W-1:0] CNT_MAX = '1;

	logic [ramx_pkg::ID_W-1:0]    own_id_q;
	logic [ramx_pkg::NCNT_W-1:0]  node_count_q;
	ramx_pkg::phase_t             phase_q, phase_d;
	logic [ramx_pkg::STAMP_W-1:0] stamp_q, stamp_d;
	logic [EW-1:0]                rc_q, rc_d;
	logic [MAX_NODES-1:0]         defer_q, defer_d;
	logic [ramx_pkg::CNT_W-1:0]   started_q, started_d;
	logic [ramx_pkg::CNT_W-1:0]   done_q, done_d;
	logic [MAX_NODES-1:0]         work_q, work_d;
	logic [IW-1:0]                idx_q;
	ramx_pkg::action_t            act_q, act_d;
	logic [ramx_pkg::ID_W-1:0]    dest_q, dest_d;
	logic                         last_q, last_d;

	logic [EW-1:0]        eff, need, rc_n;
	logic [MAX_NODES-1:0] range_mask, work_left;
	logic                 peer_first;

	always_comb begin
		eff = (32'(node_count_q) > MAX_NODES) ? EW'(MAX_NODES) : EW'(node_count_q);
		need = (eff < EW'(2)) ? '0 : eff - EW'(2);
		rc_n = (rc_q < need) ? rc_q + EW'(1) : rc_q;
		for (int i = 0; i < MAX_NODES; i++) begin
			range_mask[i] = (i >= 1) && (i < int'(eff));
		end
		peer_first = (stamp_q > stamp) || ((stamp_q == stamp) && (own_id_q > source_node));
		work_left = work_q & ~(MAX_NODES'(1) << idx_q);
	end

	// decode one item against the current node state
	always_comb begin
		phase_d = phase_q;
		stamp_d = stamp_q;
		rc_d = rc_q;
		defer_d = defer_q;
		started_d = started_q;
		done_d = done_q;
		work_d = work_q;
		act_d = ramx_pkg::ACT_MULTICAST;
		dest_d = '0;
		last_d = 1'b1;
		sts.res_now = 1'b0;
		sts.grant_next = 1'b0;
		sts.scan_go = 1'b0;
		sts.bit_hit = cmd.scan_step && work_q[idx_q];
		sts.work_empty = (work_q == '0);
		sts.out_last = last_q;
		case (mode)
			ramx_pkg::MODE_REQUEST: begin
				if (phase_q == ramx_pkg::PH_FREE) begin
					sts.res_now = 1'b1;
					stamp_d = stamp;
					rc_d = '0;
					if (need == '0) begin
						phase_d = ramx_pkg::PH_BUSY;
						sts.grant_next = 1'b1;
						last_d = 1'b0;
					end else begin
						phase_d = ramx_pkg::PH_WAIT;
					end
				end
			end
			ramx_pkg::MODE_RELEASE: begin
				if (phase_q == ramx_pkg::PH_BUSY) begin
					phase_d = ramx_pkg::PH_FREE;
					defer_d = '0;
					work_d = defer_q & range_mask;
					sts.scan_go = |(defer_q & range_mask);
				end
			end
			ramx_pkg::MODE_MESSAGE: begin
				case (msg_kind)
					ramx_pkg::MSG_STARTED: begin
						if (started_q != CNT_MAX) begin
							started_d = started_q + 1'b1;
						end
					end
					ramx_pkg::MSG_DONE: begin
						if (done_q != CNT_MAX) begin
							done_d = done_q + 1'b1;
						end
					end
					ramx_pkg::MSG_CS_REQ: begin
						if (phase_q == ramx_pkg::PH_FREE
								|| (phase_q == ramx_pkg::PH_WAIT && peer_first)) begin
							sts.res_now = 1'b1;
							act_d = ramx_pkg::ACT_REPLY;
							dest_d = source_node;
						end else if (32'(source_node) < MAX_NODES) begin
							defer_d = defer_q | (MAX_NODES'(1) << source_node);
						end
					end
					default: begin
						if (phase_q == ramx_pkg::PH_WAIT) begin
							rc_d = rc_n;
							if (rc_n >= need) begin
								phase_d = ramx_pkg::PH_BUSY;
								sts.res_now = 1'b1;
								act_d = ramx_pkg::ACT_GRANT;
							end
						end
					end
				endcase
			end
			default: begin
				sts.res_now = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_id_q <= ramx_pkg::ID_W'(1);
			node_count_q <= ramx_pkg::NCNT_W'(2);
			phase_q <= ramx_pkg::PH_FREE;
			stamp_q <= '0;
			rc_q <= '0;
			defer_q <= '0;
			started_q <= '0;
			done_q <= '0;
		end else begin
			if (cfg_write && cfg_index == ramx_pkg::CFG_OWN_ID) begin
				own_id_q <= cfg_data[ramx_pkg::ID_W-1:0];
			end
			if (cfg_write && cfg_index == ramx_pkg::CFG_NODE_COUNT) begin
				node_count_q <= cfg_data;
			end
			if (cmd.accept) begin
				phase_q <= phase_d;
				stamp_q <= stamp_d;
				rc_q <= rc_d;
				defer_q <= defer_d;
				started_q <= started_d;
				done_q <= done_d;
			end
		end
	end

	// result register and release scan
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			work_q <= work_d;
			idx_q <= IW'(1);
			if (sts.res_now) begin
				act_q <= act_d;
				dest_q <= dest_d;
				last_q <= last_d;
			end
		end else if (cmd.load_grant) begin
			act_q <= ramx_pkg::ACT_GRANT;
			dest_q <= '0;
			last_q <= 1'b1;
		end else if (cmd.scan_step) begin
			idx_q <= idx_q + 1'b1;
			if (work_q[idx_q]) begin
				work_q <= work_left;
				act_q <= ramx_pkg::ACT_REPLY;
				dest_q <= ramx_pkg::ID_W'(idx_q);
				last_q <= (work_left == '0);
			end
		end
	end

	assign action = act_q;
	assign dest_node = dest_q;
	assign last_of_run = last_q;
	assign node_phase = phase_q;
	assign started_seen = started_q;
	assign done_seen = done_q;

endmodule
